@@ hw/rtl/cmdf_pkg.sv @@
`timescale 1ns / 1ps

package cmdf_pkg;

    localparam int MAX_MESSAGE = 1024;
    localparam int INDEX_W     = $clog2(MAX_MESSAGE + 1);

    localparam logic [7:0] OP_START   = 8'hA5;
    localparam logic [7:0] OP_CONT    = 8'hA6;
    localparam logic [7:0] OP_END     = 8'hA7;
    localparam logic [7:0] OP_SINGLE  = 8'hA8;
    localparam logic [7:0] OP_RSP     = 8'hA9;
    localparam logic [15:0] SINGLE_LEN = 16'd32;
    localparam logic [7:0] ACK_SECOND = 8'h00;

    localparam int MAX_RESULTS = 4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_TRANSMIT = 2'd1,
        KIND_COMPLETE = 2'd2,
        KIND_PEER_ACK = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        PS_OPCODE   = 7'b0000001,
        PS_LEN_LO   = 7'b0000010,
        PS_LEN_HI   = 7'b0000100,
        PS_CHUNKLEN = 7'b0001000,
        PS_DATA     = 7'b0010000,
        PS_LASTDATA = 7'b0100000,
        PS_RSPDATA  = 7'b1000000
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic [10:0] message_length;
        logic        overflow;
        logic        last;
    } result_t;

    function automatic result_t make_result(kind_t kind, logic [7:0] data_byte,
                                            logic [9:0] byte_index,
                                            logic [10:0] message_length,
                                            logic overflow);
        result_t r;
        r.kind           = kind;
        r.data_byte      = data_byte;
        r.byte_index     = byte_index;
        r.message_length = message_length;
        r.overflow       = overflow;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/chunked_message_deframer.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                              Contents
// s_        in         s_tvalid s_tready s_tdata[7:0]     rx_byte
// m_        out        m_tvalid m_tready m_tdata[31:0]    data_byte, byte_index,
//                      m_tuser[1:0] m_tlast               message_length, overflow; kind; last
//
// A received byte is registered, then parsed once the result buffer is empty or its
// last result is being taken; its results (zero to four) then leave the output port
// one per cycle while m_tready is high. The first result of a byte is presented from
// the result buffer, into which the parse writes all of the byte's results.
// A new byte is taken while earlier results are still draining.
// Reset is synchronous on aresetn and returns the parser to waiting for an opcode.
module chunked_message_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [17:8] byte_index,
                                   // [28:18] message_length, [29] overflow, [31:30] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import cmdf_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg, in_byte_next;

    parse_state_t          state_reg, state_next;
    logic [7:0]            opcode_reg, opcode_next;
    logic [15:0]           decl_len_reg, decl_len_next;
    logic [7:0]            chunk_count_reg, chunk_count_next;
    logic [7:0]            chunk_len_reg, chunk_len_next;
    logic [INDEX_W-1:0]    msg_index_reg, msg_index_next;
    logic                  dropped_reg, dropped_next;

    result_t               res_reg [MAX_RESULTS];
    result_t               res_next [MAX_RESULTS];
    logic [2:0]            res_cnt_reg, res_cnt_next;
    logic [1:0]            res_pos_reg, res_pos_next;

    result_t               batch [MAX_RESULTS];
    logic [2:0]            batch_cnt;
    logic                  pop, pop_last, process, buf_empty;

    logic [7:0]            cnt_inc;
    logic                  chunk_done, stored;
    logic [INDEX_W-1:0]    index_after;
    logic                  dropped_after;

    assign buf_empty = (res_cnt_reg == 3'd0);
    assign m_tvalid  = !buf_empty;
    assign pop       = m_tvalid && m_tready;
    assign pop_last  = pop && ({1'b0, res_pos_reg} + 3'd1 == res_cnt_reg);
    assign process   = in_valid_reg && (buf_empty || pop_last);
    assign s_tready  = !in_valid_reg || process;

    assign m_tdata = {2'b00, res_reg[res_pos_reg].overflow,
                      res_reg[res_pos_reg].message_length,
                      res_reg[res_pos_reg].byte_index,
                      res_reg[res_pos_reg].data_byte};
    assign m_tuser = res_reg[res_pos_reg].kind;
    assign m_tlast = res_reg[res_pos_reg].last;

    assign cnt_inc       = chunk_count_reg + 8'd1;
    assign chunk_done    = (cnt_inc == chunk_len_reg);
    assign stored        = (msg_index_reg < INDEX_W'(MAX_MESSAGE));
    assign index_after   = stored ? msg_index_reg + INDEX_W'(1) : msg_index_reg;
    assign dropped_after = dropped_reg || !stored;

    always_comb begin
        state_next       = state_reg;
        opcode_next      = opcode_reg;
        decl_len_next    = decl_len_reg;
        chunk_count_next = chunk_count_reg;
        chunk_len_next   = chunk_len_reg;
        msg_index_next   = msg_index_reg;
        dropped_next     = dropped_reg;
        batch_cnt        = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            batch[i] = make_result(KIND_PAYLOAD, 8'd0, 10'd0, 11'd0, 1'b0);
        end

        case (state_reg)
            PS_OPCODE: begin
                if (in_byte_reg == OP_START) begin
                    decl_len_next = 16'd0;
                    state_next    = PS_LEN_LO;
                end else if (in_byte_reg == OP_CONT || in_byte_reg == OP_END) begin
                    state_next = (decl_len_reg != 16'd0) ? PS_CHUNKLEN : PS_OPCODE;
                end else if (in_byte_reg == OP_SINGLE) begin
                    decl_len_next = SINGLE_LEN;
                    state_next    = PS_CHUNKLEN;
                end else if (in_byte_reg == OP_RSP) begin
                    state_next = PS_RSPDATA;
                end
                opcode_next = in_byte_reg;
            end
            PS_LEN_LO: begin
                decl_len_next = {8'd0, in_byte_reg};
                state_next    = PS_LEN_HI;
            end
            PS_LEN_HI: begin
                decl_len_next = {in_byte_reg, decl_len_reg[7:0]};
                state_next    = PS_CHUNKLEN;
            end
            PS_CHUNKLEN: begin
                chunk_count_next = 8'd0;
                chunk_len_next   = in_byte_reg;
                if (opcode_reg == OP_START || opcode_reg == OP_CONT) begin
                    state_next = PS_DATA;
                end else if (opcode_reg == OP_END || opcode_reg == OP_SINGLE) begin
                    state_next = PS_LASTDATA;
                end else begin
                    state_next = PS_OPCODE;
                end
            end
            PS_DATA, PS_LASTDATA: begin
                chunk_count_next = cnt_inc;
                msg_index_next   = index_after;
                dropped_next     = dropped_after;
                if (stored) begin
                    batch[0]  = make_result(KIND_PAYLOAD, in_byte_reg,
                                            msg_index_reg[9:0], 11'd0, 1'b0);
                    batch_cnt = 3'd1;
                end
                if (chunk_done) begin
                    chunk_count_next = 8'd0;
                    chunk_len_next   = 8'd0;
                    state_next       = PS_OPCODE;
                    if (state_reg == PS_LASTDATA) begin
                        batch[batch_cnt[1:0]] = make_result(KIND_COMPLETE, 8'd0, 10'd0,
                                                            11'(index_after), dropped_after);
                        batch_cnt      = batch_cnt + 3'd1;
                        msg_index_next = '0;
                        dropped_next   = 1'b0;
                    end
                    batch[batch_cnt[1:0]] = make_result(KIND_TRANSMIT, OP_RSP,
                                                        10'd0, 11'd0, 1'b0);
                    batch_cnt = batch_cnt + 3'd1;
                    batch[batch_cnt[1:0]] = make_result(KIND_TRANSMIT, ACK_SECOND,
                                                        10'd0, 11'd0, 1'b0);
                    batch_cnt = batch_cnt + 3'd1;
                end
            end
            PS_RSPDATA: begin
                batch[0]   = make_result(KIND_PEER_ACK, 8'd0, 10'd0, 11'd0, 1'b0);
                batch_cnt  = 3'd1;
                state_next = PS_OPCODE;
            end
            default: begin
                state_next = PS_OPCODE;
            end
        endcase

        if (batch_cnt != 3'd0) begin
            batch[2'(batch_cnt - 3'd1)].last = 1'b1;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        res_next      = res_reg;
        res_cnt_next  = res_cnt_reg;
        res_pos_next  = res_pos_reg;

        if (process) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end

        if (pop) begin
            if (pop_last) begin
                res_cnt_next = 3'd0;
                res_pos_next = 2'd0;
            end else begin
                res_pos_next = res_pos_reg + 2'd1;
            end
        end
        if (process) begin
            res_next     = batch;
            res_cnt_next = batch_cnt;
            res_pos_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            state_reg       <= PS_OPCODE;
            opcode_reg      <= 8'd0;
            decl_len_reg    <= 16'd0;
            chunk_count_reg <= 8'd0;
            chunk_len_reg   <= 8'd0;
            msg_index_reg   <= '0;
            dropped_reg     <= 1'b0;
            res_cnt_reg     <= 3'd0;
            res_pos_reg     <= 2'd0;
        end else begin
            in_valid_reg    <= in_valid_next;
            if (process) begin
                state_reg       <= state_next;
                opcode_reg      <= opcode_next;
                decl_len_reg    <= decl_len_next;
                chunk_count_reg <= chunk_count_next;
                chunk_len_reg   <= chunk_len_next;
                msg_index_reg   <= msg_index_next;
                dropped_reg     <= dropped_next;
            end
            res_cnt_reg     <= res_cnt_next;
            res_pos_reg     <= res_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        res_reg     <= res_next;
    end

    // The result buffer holds at most four results and the read position stays inside it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_cnt_reg <= 3'd4 && {1'b0, res_pos_reg} < res_cnt_reg))
        else $error("result buffer position out of range");

    // A byte is only parsed when its results cannot overwrite undelivered ones.
    assert property (@(posedge aclk) disable iff (!aresetn)
        process |-> (buf_empty || pop_last))
        else $error("parse would overwrite pending results");

    // The message index never passes the capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        msg_index_reg <= INDEX_W'(MAX_MESSAGE))
        else $error("message index beyond capacity");

    // A parsed byte with results presents them in the next cycle, starting at the first.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (process && batch_cnt != 3'd0) |=> (m_tvalid && res_pos_reg == 2'd0))
        else $error("results of a parsed byte not presented");

endmodule

@@ tb/chunked_message_deframer_tb.sv @@
`timescale 1ns / 1ps

module chunked_message_deframer_tb;

    import cmdf_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;

    class deframer_scoreboard;

        parse_state_t state;
        logic [7:0]   opcode;
        logic [15:0]  declared_len;
        logic [7:0]   chunk_count;
        logic [7:0]   chunk_len;
        logic [10:0]  message_index;
        logic         dropped;
        result_t      awaited_results[$];
        int           mismatches;

        function new();
            state         = PS_OPCODE;
            opcode        = '0;
            declared_len  = '0;
            chunk_count   = '0;
            chunk_len     = '0;
            message_index = '0;
            dropped       = 1'b0;
            mismatches    = 0;
        endfunction

        function void add_result(kind_t kind, logic [7:0] data, logic [9:0] index,
                                 logic [10:0] length, logic ovf);
            result_t r;
            r.kind           = kind;
            r.data_byte      = data;
            r.byte_index     = index;
            r.message_length = length;
            r.overflow       = ovf;
            r.last           = 1'b0;
            awaited_results.push_back(r);
        endfunction

        function void add_ack_pair();
            add_result(KIND_TRANSMIT, OP_RSP, '0, '0, 1'b0);
            add_result(KIND_TRANSMIT, ACK_SECOND, '0, '0, 1'b0);
        endfunction

        // Stores one chunk byte and tells whether the chunk is now complete.
        function bit store_chunk_byte(logic [7:0] value);
            chunk_count = chunk_count + 8'd1;
            if (message_index < 11'(MAX_MESSAGE)) begin
                add_result(KIND_PAYLOAD, value, message_index[9:0], '0, 1'b0);
                message_index = message_index + 11'd1;
            end else begin
                dropped = 1'b1;
            end
            return chunk_count == chunk_len;
        endfunction

        function void take_rx_byte(logic [7:0] value);
            int unsigned queued;
            queued = awaited_results.size();
            case (state)
                PS_OPCODE: begin
                    if (value == OP_START) begin
                        declared_len = '0;
                        state = PS_LEN_LO;
                    end else if (value == OP_CONT || value == OP_END) begin
                        state = (declared_len != 16'd0) ? PS_CHUNKLEN : PS_OPCODE;
                    end else if (value == OP_SINGLE) begin
                        declared_len = SINGLE_LEN;
                        state = PS_CHUNKLEN;
                    end else if (value == OP_RSP) begin
                        state = PS_RSPDATA;
                    end
                    opcode = value;
                end
                PS_LEN_LO: begin
                    declared_len = {8'h00, value};
                    state = PS_LEN_HI;
                end
                PS_LEN_HI: begin
                    declared_len[15:8] = value;
                    state = PS_CHUNKLEN;
                end
                PS_CHUNKLEN: begin
                    chunk_count = '0;
                    chunk_len   = value;
                    if (opcode == OP_START || opcode == OP_CONT) begin
                        state = PS_DATA;
                    end else if (opcode == OP_END || opcode == OP_SINGLE) begin
                        state = PS_LASTDATA;
                    end else begin
                        state = PS_OPCODE;
                    end
                end
                PS_DATA: begin
                    if (store_chunk_byte(value)) begin
                        chunk_count = '0;
                        chunk_len   = '0;
                        state = PS_OPCODE;
                        add_ack_pair();
                    end
                end
                PS_LASTDATA: begin
                    if (store_chunk_byte(value)) begin
                        add_result(KIND_COMPLETE, '0, '0, message_index, dropped);
                        chunk_count   = '0;
                        chunk_len     = '0;
                        message_index = '0;
                        dropped       = 1'b0;
                        state = PS_OPCODE;
                        add_ack_pair();
                    end
                end
                PS_RSPDATA: begin
                    add_result(KIND_PEER_ACK, '0, '0, '0, 1'b0);
                    state = PS_OPCODE;
                end
                default: begin
                    state = PS_OPCODE;
                end
            endcase
            if (awaited_results.size() > queued) begin
                awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] tdata, logic last);
            result_t want;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d tdata %h last %b",
                         $time, kind, tdata, last);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("kind", want.kind, kind);
                compare_field("data_byte", want.data_byte, tdata[7:0]);
                compare_field("byte_index", want.byte_index, tdata[17:8]);
                compare_field("message_length", want.message_length, tdata[28:18]);
                compare_field("overflow", want.overflow, tdata[29]);
                compare_field("tdata padding", 0, tdata[31:30]);
                compare_field("last", want.last, last);
            end
        endfunction

    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    deframer_scoreboard sb;
    bit  gaps_on = 1'b1;
    bit  hold_off_request = 1'b0;
    int  bytes_sent = 0;
    int  ignored_bytes = 0;
    int  cycle_count = 0;

    chunked_message_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("chunked_message_deframer_tb NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] chunk_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll == 0) begin
            return 8'($urandom_range(0, 255));
        end else if (roll < 10) begin
            return 8'h01;
        end
        return 8'($urandom_range(1, 12));
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_rx_byte(value);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.awaited_results.size() != 0);
    endtask

    task automatic send_directed();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'hFF, OP_CONT, OP_END, OP_RSP, 8'hFF,
                OP_START, 8'h00, 8'h00, 8'h01, 8'hFF, OP_CONT,
                OP_START, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'h80,
                OP_CONT, 8'h01, 8'h55, OP_END, 8'h01, 8'hAA,
                OP_SINGLE, 8'h01, 8'h3C, OP_RSP, OP_START};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Four full-size chunks fill the message exactly; the closing chunk is dropped.
    task automatic send_long_message();
        send_byte(OP_START);
        send_byte(8'h00);
        send_byte(8'h04);
        for (int k = 0; k < 4; k++) begin
            if (k > 0) begin
                send_byte(OP_CONT);
            end
            send_byte(8'h00);
            repeat (256) send_byte(8'($urandom));
        end
        send_byte(OP_END);
        send_byte(8'h03);
        repeat (3) send_byte(8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] op, input bit cut_short);
        logic [7:0] len;
        int n;
        send_byte(op);
        if (op == OP_START) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'h00);
                send_byte(8'h00);
            end else begin
                send_byte(8'($urandom));
                send_byte(8'($urandom));
            end
        end
        len = chunk_size();
        n = (len == 8'h00) ? 256 : int'(len);
        if (cut_short) begin
            n = $urandom_range(0, n - 1);
        end
        send_byte(len);
        repeat (n) send_byte(8'($urandom));
    endtask

    task automatic send_traffic(input int count);
        int goal;
        int roll;
        logic [7:0] ops[4];
        ops  = '{OP_START, OP_CONT, OP_END, OP_SINGLE};
        goal = bytes_sent - ignored_bytes + count;
        while (bytes_sent - ignored_bytes < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                send_frame(OP_START, 1'b0);
            end else if (roll < 45) begin
                send_frame(OP_CONT, 1'b0);
            end else if (roll < 60) begin
                send_frame(OP_END, 1'b0);
            end else if (roll < 70) begin
                send_frame(OP_SINGLE, 1'b0);
            end else if (roll < 80) begin
                send_byte(OP_RSP);
                send_byte(8'($urandom));
            end else if (roll < 90) begin
                send_byte(8'($urandom));
                ignored_bytes++;
            end else begin
                send_frame(ops[$urandom_range(0, 3)], 1'b1);
            end
        end
    endtask

    initial begin : receiver
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_off_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_request = 1'b0;
            end else begin
                stall = idle_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        sb = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_directed();
        wait_for_results();
        send_long_message();
        wait_for_results();

        gaps_on = 1'b0;
        send_traffic(40);
        gaps_on = 1'b1;
        send_traffic(60);
        wait_for_results();
        hold_off_request = 1'b1;
        send_traffic(100);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
            $display("chunked_message_deframer_tb OK");
        end else begin
            $display("chunked_message_deframer_tb NOT OK");
        end
        $finish;
    end

endmodule
